>>> design/causal_2x2_max_filter_assert.svh
// Assertion macros shared by the causal 2x2 max filter modules.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef CAUSAL_2X2_MAX_FILTER_ASSERT_SVH
`define CAUSAL_2X2_MAX_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CMF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cmf_pkg.sv
// Shared constants and types for the causal 2x2 max filter.
// No dependencies; imported by causal_2x2_max_filter, cmf_ctrl and cmf_max_stage.
package cmf_pkg;

  localparam int MAX_COLUMNS_DEF  = 1024;
  localparam int ELEMENT_BITS_DEF = 16;
  localparam int CFG_BITS         = 11;
  localparam int ROW_LENGTH_RESET = 1024;
  localparam int ROW_LENGTH_MIN   = 2;

  typedef struct packed {
    logic first_row;
    logic col_zero;
    logic row_end;
  } cmf_ctl_t;

endpackage

>>> design/causal_2x2_max_filter.sv
// Causal 2x2 max filter: an input transfer is registered with its line store read and then
// passes the output register; one element per cycle unless result_stall raises pixel_stall.
// Reset clears the row position, sets the first-row flag and loads the row length 1024.
// The line store is not cleared; entries read during the first row of a frame are ignored.
// Depends on cmf_pkg, cmf_ctrl, cmf_line_store and cmf_max_stage.
module causal_2x2_max_filter
  import cmf_pkg::*;
#(
  parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [CFG_BITS-1:0]            row_length,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  input  logic signed [ELEMENT_BITS-1:0] pixel_value,
  input  logic                           frame_start,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [ELEMENT_BITS-1:0] window_max,
  output logic                           row_end
);

  localparam int COL_W = $clog2(MAX_COLUMNS);

  logic                           accept;
  logic [COL_W-1:0]               addr;
  cmf_ctl_t                       ctl;
  logic signed [ELEMENT_BITS-1:0] upper;

  assign cfg_ready = 1'b1;
  assign accept    = pixel_valid && !pixel_stall;

  cmf_ctrl #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (row_length),
    .accept     (accept),
    .frame_start(frame_start),
    .addr       (addr),
    .ctl        (ctl)
  );

  cmf_line_store #(
    .DEPTH(MAX_COLUMNS),
    .WIDTH(ELEMENT_BITS)
  ) u_line_store (
    .clk  (clk),
    .en   (accept),
    .addr (addr),
    .wdata(pixel_value),
    .rdata(upper)
  );

  cmf_max_stage #(
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_max_stage (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .x_in        (pixel_value),
    .ctl_in      (ctl),
    .upper       (upper),
    .busy        (pixel_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .window_max  (window_max),
    .row_end     (row_end)
  );

endmodule

>>> design/cmf_line_store.sv
// Previous-row line store: single-port synchronous RAM, read-before-write.
// Depends on nothing outside this file.
module cmf_line_store #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

>>> design/cmf_ctrl.sv
// Row length register and raster position tracker of the causal 2x2 max filter.
// Depends on cmf_pkg and the assertion macro header.
`include "causal_2x2_max_filter_assert.svh"

module cmf_ctrl
  import cmf_pkg::*;
#(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_BITS-1:0]            cfg_data,
  input  logic                           accept,
  input  logic                           frame_start,
  output logic [$clog2(MAX_COLUMNS)-1:0] addr,
  output cmf_ctl_t                       ctl
);

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int LEN_W     = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W     = (LEN_W > CFG_BITS) ? LEN_W : CFG_BITS;
  localparam int RESET_LEN = (ROW_LENGTH_RESET > MAX_COLUMNS) ? MAX_COLUMNS : ROW_LENGTH_RESET;

  logic [LEN_W-1:0] eff_len;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_next;
  logic             first;
  logic             first_next;
  logic [CMP_W-1:0] cfg_wide;
  logic [COL_W-1:0] cur_col;
  logic             cur_first;
  logic             row_end;

  assign cfg_wide = CMP_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_len <= LEN_W'(RESET_LEN);
    end else if (cfg_we) begin
      if (cfg_wide < CMP_W'(ROW_LENGTH_MIN)) begin
        eff_len <= LEN_W'(ROW_LENGTH_MIN);
      end else if (cfg_wide > CMP_W'(MAX_COLUMNS)) begin
        eff_len <= LEN_W'(MAX_COLUMNS);
      end else begin
        eff_len <= LEN_W'(cfg_wide);
      end
    end
  end

  always_comb begin
    cur_col   = frame_start ? '0 : col;
    cur_first = frame_start ? 1'b1 : first;
    if (LEN_W'(cur_col) >= eff_len) begin
      cur_col   = '0;
      cur_first = 1'b0;
    end
    row_end    = (LEN_W'(cur_col) + LEN_W'(1)) >= eff_len;
    col_next   = row_end ? '0 : cur_col + COL_W'(1);
    first_next = row_end ? 1'b0 : cur_first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      first <= 1'b1;
    end else if (accept) begin
      col   <= col_next;
      first <= first_next;
    end
  end

  assign addr          = cur_col;
  assign ctl.first_row = cur_first;
  assign ctl.col_zero  = (cur_col == '0);
  assign ctl.row_end   = row_end;

  `CMF_ASSERT_SAME(a_addr_in_row, accept, LEN_W'(addr) < eff_len, "column outside the row")
  `CMF_ASSERT_SAME(a_frame_start_first, accept && frame_start, ctl.first_row && ctl.col_zero,
                   "frame start did not restart the frame")
  `CMF_ASSERT_NEXT(a_row_end_wraps, accept && ctl.row_end, col == '0 && !first,
                   "row end did not wrap to a new row")

endmodule

>>> design/cmf_max_stage.sv
// Window maximum stage with neighbor registers and the output register.
// Depends on cmf_pkg and the assertion macro header.
`include "causal_2x2_max_filter_assert.svh"

module cmf_max_stage
  import cmf_pkg::*;
#(
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic signed [ELEMENT_BITS-1:0] x_in,
  input  cmf_ctl_t                       ctl_in,
  input  logic signed [ELEMENT_BITS-1:0] upper,
  output logic                           busy,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic signed [ELEMENT_BITS-1:0] window_max,
  output logic                           row_end
);

  logic                           s1_valid;
  logic signed [ELEMENT_BITS-1:0] s1_x;
  cmf_ctl_t                       s1_ctl;
  logic signed [ELEMENT_BITS-1:0] left_element;
  logic signed [ELEMENT_BITS-1:0] upper_left_element;
  logic signed [ELEMENT_BITS-1:0] best;
  logic                           s1_advance;

  assign s1_advance = s1_valid && (!result_valid || !result_stall);
  assign busy       = s1_valid && !s1_advance;

  always_comb begin
    best = s1_x;
    if (!s1_ctl.col_zero && left_element > best) begin
      best = left_element;
    end
    if (!s1_ctl.first_row) begin
      if (upper > best) begin
        best = upper;
      end
      if (!s1_ctl.col_zero && upper_left_element > best) begin
        best = upper_left_element;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_x   <= x_in;
      s1_ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_element       <= '0;
      upper_left_element <= '0;
    end else if (s1_advance) begin
      left_element       <= s1_x;
      upper_left_element <= upper;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      window_max <= best;
      row_end    <= s1_ctl.row_end;
    end
  end

  `CMF_ASSERT_SAME(a_busy_needs_item, busy, s1_valid && result_valid && result_stall,
                   "stage reports busy without a blocked item")
  `CMF_ASSERT_NEXT(a_advance_fills_out, s1_advance, result_valid,
                   "advanced item did not reach the output register")
  `CMF_ASSERT_NEXT(a_drain_empties_out, result_valid && !result_stall && !s1_valid,
                   !result_valid, "output register kept a transferred result")

endmodule
